/* hw/rtl/tdh_pkg.sv */
// ----------------------------------------------------------------------------
// Target depth histogram package
// Shared sizes, item mode codes, memory word types and the bin clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package tdh_pkg;

    localparam int BINS    = 256;
    localparam int REGIONS = 1024;

    localparam int CHROM_W = 8;
    localparam int COORD_W = 32;
    localparam int DEPTH_W = 24;
    localparam int COUNT_W = 32;
    localparam int MAXD_W  = 8;
    localparam int MODE_W  = 2;

    localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int RA_W  = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int CNT_W = $clog2(REGIONS + 1);

    localparam logic [MAXD_W-1:0] MAX_DEPTH_RESET = MAXD_W'(255);

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_SAMPLE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [COORD_W-1:0] start;
        logic [COORD_W-1:0] finish;
    } t_region;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic             wr_on;
        logic [BIN_W-1:0] addr;
    } t_hist_ctl;

    function automatic logic [BIN_W-1:0] clamp_bin(input logic [DEPTH_W-1:0] depth,
                                                   input logic [MAXD_W-1:0]  max_depth);
        logic [DEPTH_W-1:0] b;
        b = depth;
        if (b > DEPTH_W'(max_depth)) begin
            b = DEPTH_W'(max_depth);
        end
        if (b > DEPTH_W'(BINS - 1)) begin
            b = DEPTH_W'(BINS - 1);
        end
        return b[BIN_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/target_depth_histogram.sv */
// Load, unused-mode, out-of-range read and post-error sample items give their
// result through the output register alone; a bin read also passes through the
// histogram read register and ST_HIST. A sample steps its pointer in ST_SCAN
// past the regions that lie before its position, then updates its bin in ST_HIST.
// One item is in work at a time. Reset is synchronous; after it a clearing
// pass zeroes both histograms while the input is stalled.
// ----------------------------------------------------------------------------
// Target depth histogram
// Loads sorted target regions, classifies depth samples as on-target or
// off-target against them and counts clamped depths in two histograms.
// ----------------------------------------------------------------------------
`default_nettype none

module target_depth_histogram (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [tdh_pkg::MAXD_W-1:0]  i_cfg_wr_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [tdh_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [tdh_pkg::CHROM_W-1:0] i_chrom,
    input  wire logic [tdh_pkg::COORD_W-1:0] i_region_start,
    input  wire logic [tdh_pkg::COORD_W-1:0] i_region_end,
    input  wire logic [tdh_pkg::COORD_W-1:0] i_position,
    input  wire logic [tdh_pkg::DEPTH_W-1:0] i_depth,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_on_target,
    output logic [tdh_pkg::COUNT_W-1:0]      o_on_count,
    output logic [tdh_pkg::COUNT_W-1:0]      o_off_count,
    output logic                             o_sort_error,
    output logic                             o_table_full
);
    import tdh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HIST = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [MAXD_W-1:0]  r_max_depth;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_ptr, n_ptr;
    logic               r_err, n_err;
    t_region            r_last, n_last;
    logic [CHROM_W-1:0] r_chrom, n_chrom;
    logic [COORD_W-1:0] r_pos, n_pos;
    logic [BIN_W-1:0]   r_bin, n_bin;
    logic               r_is_read, n_is_read;
    logic               r_on, n_on;

    logic               r_out_valid, n_out_valid;
    logic               r_out_on, n_out_on;
    logic [COUNT_W-1:0] r_out_onc, n_out_onc;
    logic [COUNT_W-1:0] r_out_offc, n_out_offc;
    logic               r_out_err, n_out_err;
    logic               r_out_full, n_out_full;

    logic               in_xfer;
    logic               emit;
    logic               e_on;
    logic [COUNT_W-1:0] e_onc;
    logic [COUNT_W-1:0] e_offc;
    logic               e_full;
    logic               bad_order;
    logic               passed;
    logic [CNT_W-1:0]   ptr_inc;
    logic [COUNT_W-1:0] cur_cnt;

    logic               reg_wr_en;
    t_region            reg_wr_data;
    logic               reg_rd_en;
    logic [RA_W-1:0]    reg_rd_addr;
    t_region            reg_rd_data;

    t_hist_ctl          hist_ctl;
    logic [COUNT_W-1:0] hist_wr_data;
    logic               hist_busy;
    logic [COUNT_W-1:0] hist_rd_on;
    logic [COUNT_W-1:0] hist_rd_off;

    tdh_region_mem u_regions (
        .i_clk     (i_clk),
        .i_wr_en   (reg_wr_en),
        .i_wr_addr (r_count[RA_W-1:0]),
        .i_wr_data (reg_wr_data),
        .i_rd_en   (reg_rd_en),
        .i_rd_addr (reg_rd_addr),
        .o_rd_data (reg_rd_data)
    );

    tdh_hist_mem u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (hist_ctl),
        .i_wr_data (hist_wr_data),
        .o_busy    (hist_busy),
        .o_rd_on   (hist_rd_on),
        .o_rd_off  (hist_rd_off)
    );

    assign o_in_stall = (r_state != ST_IDLE) || hist_busy || (r_out_valid && i_out_stall);
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign bad_order = (i_chrom < r_last.chrom) ||
                       ((i_chrom == r_last.chrom) &&
                        ((i_region_start < r_last.start) ||
                         ((i_region_start == r_last.start) &&
                          (i_region_end < r_last.finish))));

    assign passed  = (reg_rd_data.chrom < r_chrom) ||
                     ((reg_rd_data.chrom == r_chrom) && (reg_rd_data.finish < r_pos));
    assign ptr_inc = r_ptr + CNT_W'(1);
    assign cur_cnt = r_on ? hist_rd_on : hist_rd_off;

    assign reg_wr_data.chrom  = i_chrom;
    assign reg_wr_data.start  = i_region_start;
    assign reg_wr_data.finish = i_region_end;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_err       = r_err;
        n_last      = r_last;
        n_chrom     = r_chrom;
        n_pos       = r_pos;
        n_bin       = r_bin;
        n_is_read   = r_is_read;
        n_on        = r_on;
        n_out_valid = r_out_valid;
        n_out_on    = r_out_on;
        n_out_onc   = r_out_onc;
        n_out_offc  = r_out_offc;
        n_out_err   = r_out_err;
        n_out_full  = r_out_full;
        emit        = 1'b0;
        e_on        = 1'b0;
        e_onc       = '0;
        e_offc      = '0;
        e_full      = 1'b0;
        reg_wr_en   = 1'b0;
        reg_rd_en   = 1'b0;
        reg_rd_addr = r_ptr[RA_W-1:0];
        hist_ctl    = '{rd_en: 1'b0, wr_en: 1'b0, wr_on: r_on, addr: r_bin};
        hist_wr_data = (&cur_cnt) ? cur_cnt : cur_cnt + COUNT_W'(1);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_chrom = i_chrom;
                    n_pos   = i_position;
                    n_bin   = clamp_bin(i_depth, r_max_depth);
                    case (t_mode'(i_mode))
                        MODE_LOAD: begin
                            emit = 1'b1;
                            if (r_count >= CNT_W'(REGIONS)) begin
                                e_full = 1'b1;
                            end else if ((r_count != '0) && bad_order) begin
                                n_err = 1'b1;
                            end else begin
                                reg_wr_en = 1'b1;
                                n_last    = reg_wr_data;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        MODE_SAMPLE: begin
                            n_is_read = 1'b0;
                            if (r_err) begin
                                emit = 1'b1;
                            end else if (r_ptr < r_count) begin
                                reg_rd_en = 1'b1;
                                n_state   = ST_SCAN;
                            end else begin
                                n_on           = 1'b0;
                                hist_ctl.rd_en = 1'b1;
                                hist_ctl.addr  = clamp_bin(i_depth, r_max_depth);
                                n_state        = ST_HIST;
                            end
                        end
                        MODE_READ: begin
                            if (i_depth < DEPTH_W'(BINS)) begin
                                n_is_read      = 1'b1;
                                hist_ctl.rd_en = 1'b1;
                                hist_ctl.addr  = i_depth[BIN_W-1:0];
                                n_state        = ST_HIST;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (passed) begin
                    n_ptr = ptr_inc;
                    if (ptr_inc < r_count) begin
                        reg_rd_en   = 1'b1;
                        reg_rd_addr = ptr_inc[RA_W-1:0];
                    end else begin
                        n_on           = 1'b0;
                        hist_ctl.rd_en = 1'b1;
                        n_state        = ST_HIST;
                    end
                end else begin
                    n_on = (reg_rd_data.chrom == r_chrom) && (reg_rd_data.start < r_pos);
                    hist_ctl.rd_en = 1'b1;
                    n_state        = ST_HIST;
                end
            end
            ST_HIST: begin
                emit    = 1'b1;
                n_state = ST_IDLE;
                if (r_is_read) begin
                    e_onc  = hist_rd_on;
                    e_offc = hist_rd_off;
                end else begin
                    hist_ctl.wr_en = 1'b1;
                    e_on           = r_on;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
            n_out_on    = e_on;
            n_out_onc   = e_onc;
            n_out_offc  = e_offc;
            n_out_err   = n_err;
            n_out_full  = e_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_max_depth <= MAX_DEPTH_RESET;
            r_count     <= '0;
            r_ptr       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_max_depth <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last     <= n_last;
        r_chrom    <= n_chrom;
        r_pos      <= n_pos;
        r_bin      <= n_bin;
        r_is_read  <= n_is_read;
        r_on       <= n_on;
        r_out_on   <= n_out_on;
        r_out_onc  <= n_out_onc;
        r_out_offc <= n_out_offc;
        r_out_err  <= n_out_err;
        r_out_full <= n_out_full;
    end

    assign o_out_valid  = r_out_valid;
    assign o_on_target  = r_out_on;
    assign o_on_count   = r_out_onc;
    assign o_off_count  = r_out_offc;
    assign o_sort_error = r_out_err;
    assign o_table_full = r_out_full;

endmodule

`default_nettype wire

/* hw/rtl/tdh_region_mem.sv */
// ----------------------------------------------------------------------------
// Target region table
// Synchronous memory of loaded regions with one write port and a registered
// read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tdh_region_mem (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [tdh_pkg::RA_W-1:0] i_wr_addr,
    input  wire tdh_pkg::t_region     i_wr_data,
    input  wire logic                 i_rd_en,
    input  wire logic [tdh_pkg::RA_W-1:0] i_rd_addr,
    output tdh_pkg::t_region          o_rd_data
);
    import tdh_pkg::*;

    t_region r_mem [REGIONS];
    t_region r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hw/rtl/tdh_hist_mem.sv */
// ----------------------------------------------------------------------------
// Depth histogram store
// On-target and off-target bin memories sharing one address. After reset a
// clearing pass writes zero to one bin of each memory per cycle and holds
// o_busy high until it is done.
// ----------------------------------------------------------------------------
`default_nettype none

module tdh_hist_mem (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire tdh_pkg::t_hist_ctl       i_ctl,
    input  wire logic [tdh_pkg::COUNT_W-1:0] i_wr_data,
    output logic                          o_busy,
    output logic [tdh_pkg::COUNT_W-1:0]   o_rd_on,
    output logic [tdh_pkg::COUNT_W-1:0]   o_rd_off
);
    import tdh_pkg::*;

    logic [COUNT_W-1:0] r_mem_on  [BINS];
    logic [COUNT_W-1:0] r_mem_off [BINS];
    logic [COUNT_W-1:0] r_rd_on;
    logic [COUNT_W-1:0] r_rd_off;
    logic               r_clr_busy;
    logic [BIN_W-1:0]   r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + BIN_W'(1);
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem_on[r_clr_addr]  <= '0;
            r_mem_off[r_clr_addr] <= '0;
        end else if (i_ctl.wr_en) begin
            if (i_ctl.wr_on) begin
                r_mem_on[i_ctl.addr] <= i_wr_data;
            end else begin
                r_mem_off[i_ctl.addr] <= i_wr_data;
            end
        end
        if (i_ctl.rd_en) begin
            r_rd_on  <= r_mem_on[i_ctl.addr];
            r_rd_off <= r_mem_off[i_ctl.addr];
        end
    end

    assign o_busy   = r_clr_busy;
    assign o_rd_on  = r_rd_on;
    assign o_rd_off = r_rd_off;

endmodule

`default_nettype wire

/* hw/rtl/tdh_checker.sv */
// ----------------------------------------------------------------------------
// Target depth histogram checker
// Port-level assertions on result contents and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tdh_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic                        o_on_target,
    input wire logic [tdh_pkg::COUNT_W-1:0] o_on_count,
    input wire logic [tdh_pkg::COUNT_W-1:0] o_off_count,
    input wire logic                        o_sort_error,
    input wire logic                        o_table_full
);
    import tdh_pkg::*;

    logic r_seen_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_err <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_sort_error) begin
            r_seen_err <= 1'b1;
        end
    end

    // Once a result has shown a sort error, every later result shows it too.
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_seen_err) |-> o_sort_error)
        else $error("sort error flag cleared after being reported");

    a_on_target_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_on_target) |->
            (o_on_count == '0) && (o_off_count == '0) && !o_table_full)
        else $error("on-target sample result carries other fields");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_full) |->
            !o_on_target && (o_on_count == '0) && (o_off_count == '0))
        else $error("table full result carries other fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            o_out_valid && $stable(o_on_count) && $stable(o_off_count) &&
            $stable(o_on_target) && $stable(o_sort_error) && $stable(o_table_full))
        else $error("stalled result changed");

endmodule

bind target_depth_histogram tdh_checker u_tdh_checker (.*);

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Target depth histogram testbench
// Sends region loads, depth samples and bin reads as sorted genome walks
// with random content, predicts every result in a model of its own and
// compares each result transfer field by field. Both channels idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import tdh_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_LOADS  = 195;

    typedef struct packed {
        t_mode              mode;
        logic [CHROM_W-1:0] chrom;
        logic [COORD_W-1:0] rstart;
        logic [COORD_W-1:0] rend;
        logic [COORD_W-1:0] pos;
        logic [DEPTH_W-1:0] depth;
    } t_item;

    typedef struct packed {
        logic               on_target;
        logic [COUNT_W-1:0] on_count;
        logic [COUNT_W-1:0] off_count;
        logic               sort_error;
        logic               table_full;
    } t_answer;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [MAXD_W-1:0]  cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               out_stall   = 1'b0;
    t_item              in_item     = '0;
    wire                in_stall;
    wire                out_valid;
    wire                on_target;
    wire [COUNT_W-1:0]  on_count;
    wire [COUNT_W-1:0]  off_count;
    wire                sort_error;
    wire                table_full;

    t_item   work_q[$];
    t_answer answer_q[$];
    int      errors    = 0;
    int      send_idle = 0;
    int      recv_idle = 0;
    int      hold_left = 0;
    bit      hold_arm  = 1'b0;
    bit      hold_done = 1'b0;

    // Predicted state of the block.
    logic [CHROM_W-1:0] tgt_chrom [REGIONS];
    logic [COORD_W-1:0] tgt_begin [REGIONS];
    logic [COORD_W-1:0] tgt_finish [REGIONS];
    logic [COUNT_W-1:0] on_hist [BINS];
    logic [COUNT_W-1:0] off_hist [BINS];
    int unsigned        tgt_count = 0;
    int unsigned        tgt_ptr   = 0;
    logic               sort_flag = 1'b0;
    logic [MAXD_W-1:0]  model_max = MAX_DEPTH_RESET;

    int n_load   = 0;
    int n_full   = 0;
    int n_sample = 0;
    int n_on     = 0;
    int n_read   = 0;
    int n_other  = 0;

    // Generator state for the sorted walk over the genome.
    int unsigned       gen_chrom  = 0;
    longint unsigned   gen_cursor = 0;
    int unsigned       last_chrom = 0;
    int unsigned       last_start = 0;
    int unsigned       last_end   = 0;
    int                gen_stored = 0;

    target_depth_histogram u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_mode         (in_item.mode),
        .i_chrom        (in_item.chrom),
        .i_region_start (in_item.rstart),
        .i_region_end   (in_item.rend),
        .i_position     (in_item.pos),
        .i_depth        (in_item.depth),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_on_target    (on_target),
        .o_on_count     (on_count),
        .o_off_count    (off_count),
        .o_sort_error   (sort_error),
        .o_table_full   (table_full)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic t_answer classify_item(input t_item it);
        t_answer     a;
        int unsigned last;
        int unsigned bin;
        logic        bad;
        logic        hit;
        a = '0;
        case (it.mode)
            MODE_LOAD: begin
                n_load++;
                if (tgt_count >= REGIONS) begin
                    a.table_full = 1'b1;
                    n_full++;
                end else begin
                    bad = 1'b0;
                    if (tgt_count > 0) begin
                        last = tgt_count - 1;
                        bad = it.chrom < tgt_chrom[last] ||
                              (it.chrom == tgt_chrom[last] &&
                               (it.rstart < tgt_begin[last] ||
                                (it.rstart == tgt_begin[last] &&
                                 it.rend < tgt_finish[last])));
                    end
                    if (bad) begin
                        sort_flag = 1'b1;
                    end else begin
                        tgt_chrom[tgt_count]  = it.chrom;
                        tgt_begin[tgt_count]  = it.rstart;
                        tgt_finish[tgt_count] = it.rend;
                        tgt_count++;
                    end
                end
            end
            MODE_SAMPLE: begin
                n_sample++;
                if (!sort_flag) begin
                    while (tgt_ptr < tgt_count &&
                           (tgt_chrom[tgt_ptr] < it.chrom ||
                            (tgt_chrom[tgt_ptr] == it.chrom &&
                             tgt_finish[tgt_ptr] < it.pos))) begin
                        tgt_ptr++;
                    end
                    hit = 1'b0;
                    if (tgt_ptr < tgt_count) begin
                        hit = tgt_chrom[tgt_ptr] == it.chrom && tgt_begin[tgt_ptr] < it.pos;
                    end
                    bin = it.depth;
                    if (bin > model_max) begin
                        bin = model_max;
                    end
                    if (bin > BINS - 1) begin
                        bin = BINS - 1;
                    end
                    if (hit) begin
                        n_on++;
                        if (on_hist[bin] != '1) begin
                            on_hist[bin] = on_hist[bin] + 1'b1;
                        end
                    end else if (off_hist[bin] != '1) begin
                        off_hist[bin] = off_hist[bin] + 1'b1;
                    end
                    a.on_target = hit;
                end
            end
            MODE_READ: begin
                n_read++;
                if (it.depth < BINS) begin
                    a.on_count  = on_hist[it.depth];
                    a.off_count = off_hist[it.depth];
                end
            end
            default: begin
                n_other++;
            end
        endcase
        a.sort_error = sort_flag;
        return a;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                answer_q.push_back(classify_item(in_item));
            end
            if (!in_valid || !in_stall) begin
                if (work_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    in_item  <= work_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : result_monitor
        t_answer want;
        if (rst_n && out_valid && !out_stall) begin
            if (answer_q.size() == 0) begin
                $display("%0t: result transfer with nothing expected, actual %b %0h %0h %b %b",
                         $time, on_target, on_count, off_count, sort_error, table_full);
                errors++;
            end else begin
                want = answer_q.pop_front();
                check_field("on_target", want.on_target, on_target);
                check_field("on_count", want.on_count, on_count);
                check_field("off_count", want.off_count, off_count);
                check_field("sort_error", want.sort_error, sort_error);
                check_field("table_full", want.table_full, table_full);
            end
        end
        out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    function automatic int unsigned clip32(input longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic int unsigned pick_depth();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) begin
            return $urandom_range(300);
        end else if (r < 75) begin
            return (model_max == 0) ? $urandom_range(1) : model_max - 1 + $urandom_range(2);
        end
        return $urandom() & 32'hFF_FFFF;
    endfunction

    function automatic int unsigned pick_bin();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) begin
            return $urandom_range(BINS - 1);
        end else if (r < 85) begin
            return model_max;
        end
        return $urandom_range(32'hFF_FFFF, BINS);
    endfunction

    function automatic longint unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) begin
            return 0;
        end else if (r < 75) begin
            return $urandom_range(200);
        end
        return $urandom_range(100000);
    endfunction

    function automatic longint unsigned pick_origin();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50) begin
            return $urandom_range(1000);
        end else if (r < 80) begin
            return $urandom_range(32'h10_0000);
        end
        return $urandom();
    endfunction

    task automatic add_item(input t_mode m, input int unsigned ch, input int unsigned st,
                            input int unsigned en, input int unsigned ps,
                            input int unsigned dp);
        t_item it;
        it.mode   = m;
        it.chrom  = CHROM_W'(ch);
        it.rstart = st;
        it.rend   = en;
        it.pos    = ps;
        it.depth  = DEPTH_W'(dp);
        work_q.push_back(it);
    endtask

    // Only in-order regions pass through here; an equal start never carries a
    // smaller end than the region before it.
    task automatic plan_load(input int unsigned ch, input int unsigned st,
                             input int unsigned en);
        if (ch == last_chrom && st == last_start && en < last_end) begin
            en = last_end;
        end
        last_chrom = ch;
        last_start = st;
        last_end   = en;
        gen_stored++;
        add_item(MODE_LOAD, ch, st, en, $urandom(), $urandom());
    endtask

    task automatic plan_segment(input int unsigned cap);
        longint unsigned s_q[$];
        longint unsigned e_q[$];
        longint unsigned s;
        longint unsigned e;
        longint unsigned cand;
        longint unsigned prev;
        int unsigned     nxt;
        int              n;
        int              m;
        int              j;
        nxt = gen_chrom + $urandom_range(2);
        if (nxt > cap) begin
            nxt = cap;
        end
        if (nxt != gen_chrom) begin
            gen_chrom  = nxt;
            gen_cursor = pick_origin();
        end
        n = $urandom_range(8, 1);
        repeat (n) begin
            s = clip32(gen_cursor + pick_gap());
            gen_cursor = s;
            if ($urandom_range(99) < 5) begin
                e = s >> 1;
            end else if ($urandom_range(99) < 85) begin
                e = clip32(s + $urandom_range(300));
            end else begin
                e = clip32(s + $urandom_range(1000000));
            end
            plan_load(gen_chrom, s, e);
            s_q.push_back(s);
            e_q.push_back(last_end);
        end
        m = $urandom_range(4);
        j = 0;
        prev = 0;
        repeat (m) begin
            j = j + $urandom_range(1);
            if (j >= n) begin
                j = n - 1;
            end
            case ($urandom_range(6))
                0: cand = s_q[j];
                1: cand = s_q[j] + 1;
                2: cand = e_q[j];
                3: cand = e_q[j] + 1;
                4: cand = s_q[j] + $urandom_range(400);
                5: cand = (s_q[j] > 10) ? s_q[j] - $urandom_range(10, 1) : 0;
                default: cand = e_q[j] + $urandom_range(5000, 2);
            endcase
            if (cand < prev) begin
                cand = prev;
            end
            prev = cand;
            add_item(MODE_SAMPLE, gen_chrom, $urandom(), $urandom(), clip32(cand),
                     pick_depth());
        end
        if ($urandom_range(99) < 30) begin
            add_item(MODE_READ, $urandom_range(255), $urandom(), $urandom(), $urandom(),
                     pick_bin());
        end
        if ($urandom_range(99) < 10) begin
            if (gen_chrom != 0 && $urandom_range(1) == 1) begin
                add_item(MODE_SAMPLE, $urandom_range(gen_chrom - 1), $urandom(), $urandom(),
                         $urandom(), pick_depth());
            end else begin
                add_item(MODE_NONE, $urandom_range(255), $urandom(), $urandom(), $urandom(),
                         $urandom());
            end
        end
    endtask

    task automatic wait_idle();
        do begin
            @(negedge clk);
        end while (work_q.size() != 0 || in_valid || answer_q.size() != 0);
    endtask

    task automatic set_max_depth(input int unsigned v);
        wait_idle();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= MAXD_W'(v);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_max = MAXD_W'(v);
        @(negedge clk);
    endtask

    initial begin : stimulus
        int          p;
        int unsigned s;
        for (int b = 0; b < BINS; b++) begin
            on_hist[b]  = '0;
            off_hist[b] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle = 18;
        recv_idle = 58;

        // Reads of an empty histogram, out-of-range reads and the unused mode.
        add_item(MODE_READ, 0, 0, 0, 0, 0);
        add_item(MODE_READ, 255, '1, '1, '1, 32'hFF_FFFF);
        add_item(MODE_READ, 0, 0, 0, 0, BINS);
        add_item(MODE_NONE, 255, '1, '1, '1, 32'hFF_FFFF);
        // A sample before any region is loaded; the depth clamps to the reset maximum.
        add_item(MODE_SAMPLE, 0, 0, 0, 1, 32'hFF_FFFF);
        plan_load(0, 5, 20);
        add_item(MODE_SAMPLE, 0, 0, 0, 0, 0);
        add_item(MODE_SAMPLE, 0, 0, 0, 5, 1);
        add_item(MODE_SAMPLE, 0, 0, 0, 6, 255);
        add_item(MODE_SAMPLE, 0, 0, 0, 20, 256);
        plan_load(0, 5, 20);
        plan_load(0, 5, 25);
        plan_load(0, 40, 30);
        add_item(MODE_SAMPLE, 0, 0, 0, 21, 7);
        add_item(MODE_SAMPLE, 0, 0, 0, 41, 2);
        add_item(MODE_READ, 0, 0, 0, 0, 255);
        add_item(MODE_READ, 0, 0, 0, 0, 0);
        plan_load(1, 0, 32'hFFFF_FFFF);
        add_item(MODE_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF, 3);
        add_item(MODE_SAMPLE, 1, 0, 0, 32'hFFFF_FFFF, 3);
        add_item(MODE_READ, 0, 0, 0, 0, 3);
        add_item(MODE_READ, 0, 0, 0, 0, 7);
        gen_chrom  = 1;
        gen_cursor = 0;

        for (p = 1; p <= 5; p++) begin
            case (p)
                1: set_max_depth(1);
                2: set_max_depth(255);
                3: set_max_depth(0);
                4: set_max_depth($urandom_range(254, 2));
                default: set_max_depth(128);
            endcase
            send_idle = (p <= 2) ? 18 : (p <= 4) ? 58 : 0;
            recv_idle = (p <= 2) ? 58 : (p <= 4) ? 18 : 0;
            hold_arm  = (p == 2);
            while (gen_stored < 5 + p * PHASE_LOADS) begin
                plan_segment(254);
            end
        end

        // Last chromosome, then a sort error, then filling the region store.
        set_max_depth($urandom_range(255, 1));
        gen_chrom  = 255;
        gen_cursor = pick_origin();
        while (gen_stored < 1000) begin
            plan_segment(255);
        end
        add_item(MODE_LOAD, 254, 0, 0, 0, 0);
        if (last_start > 0) begin
            add_item(MODE_LOAD, 255, last_start - 1, '1, 0, 0);
        end
        if (last_end > 0) begin
            add_item(MODE_LOAD, 255, last_start, last_end - 1, 0, 0);
        end
        repeat (4) begin
            add_item(MODE_SAMPLE, 255, $urandom(), $urandom(), clip32(last_start + 1),
                     pick_depth());
        end
        repeat (3) begin
            add_item(MODE_READ, $urandom_range(255), 0, 0, 0, pick_bin());
        end
        while (gen_stored < REGIONS - 1) begin
            s = clip32(gen_cursor + pick_gap());
            gen_cursor = s;
            plan_load(255, s, clip32(s + $urandom_range(300)));
        end
        plan_load(255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(MODE_LOAD, 255, '1, '1, 0, 0);
        add_item(MODE_LOAD, 0, 0, 0, 0, 0);
        add_item(MODE_SAMPLE, 255, 0, 0, '1, pick_depth());
        repeat (24) begin
            add_item(MODE_READ, $urandom_range(255), $urandom(), $urandom(), $urandom(),
                     pick_bin());
        end
        add_item(MODE_NONE, 0, 0, 0, 0, 0);

        wait_idle();
        repeat (20) @(posedge clk);
        $display("Covered %0d region loads (%0d refused by a full store), %0d depth samples",
                 n_load, n_full, n_sample);
        $display("(%0d on target), %0d bin reads and %0d unused-mode items; sort error %0b.",
                 n_on, n_read, n_other, sort_flag);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* target_depth_histogram.f */
hw/rtl/tdh_pkg.sv
hw/rtl/tdh_region_mem.sv
hw/rtl/tdh_hist_mem.sv
hw/rtl/target_depth_histogram.sv
hw/rtl/tdh_checker.sv
bench/tb.sv
